FILE: src/lvw3d_pkg.sv
// Shared constants and types of the 3D line voxel walker.
package lvw3d_pkg;

	localparam int KEY_BITS_DEF = 16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_NEXT = 1'b1;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

endpackage

FILE: src/lvw3d_req_if.sv
// Request channel of the line voxel walker: a load or a next-voxel item.
interface lvw3d_req_if #(
	parameter int KEY_BITS = lvw3d_pkg::KEY_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic                mode;
	logic [KEY_BITS-1:0] start_x;
	logic [KEY_BITS-1:0] start_y;
	logic [KEY_BITS-1:0] start_z;
	logic [KEY_BITS-1:0] end_x;
	logic [KEY_BITS-1:0] end_y;
	logic [KEY_BITS-1:0] end_z;

	modport source (
		output valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
		input  ready
	);

	modport sink (
		input  valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready
	);
endinterface

FILE: src/lvw3d_rsp_if.sv
// Response channel of the line voxel walker: one emitted voxel item.
interface lvw3d_rsp_if #(
	parameter int KEY_BITS = lvw3d_pkg::KEY_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] voxel_x;
	logic [KEY_BITS-1:0] voxel_y;
	logic [KEY_BITS-1:0] voxel_z;
	logic                has_voxel;
	logic                is_last;

	modport source (
		output valid, voxel_x, voxel_y, voxel_z, has_voxel, is_last,
		input  ready
	);

	modport sink (
		input  valid, voxel_x, voxel_y, voxel_z, has_voxel, is_last,
		output ready
	);
endinterface

FILE: src/line_voxel_walker_3d_core.sv
// Top level of the 3D Bresenham line voxel walker.
// A next-voxel item passes the input register, then the result register. Throughput: one
// item per cycle while results are taken; the walk state updates once per item in a single
// pass of adds and compares on the error terms between the input and result registers.
// Load items produce no result and take effect for the next item right away.
// Reset (arst_n low) clears all walk state: no line is loaded and both registers are empty.
module line_voxel_walker_3d_core #(
	parameter int KEY_BITS = lvw3d_pkg::KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lvw3d_req_if.sink         req,
	lvw3d_rsp_if.source       rsp
);
	import lvw3d_pkg::*;

	localparam int ERR_W = KEY_BITS + 3;

	function automatic logic [KEY_BITS-1:0] step_key(input logic [KEY_BITS-1:0] k,
	                                                 input logic neg);
		return neg ? (k - 1'b1) : (k + 1'b1);
	endfunction

	// Input register.
	logic                     v_s1;
	logic                     mode_s1;
	logic [2:0][KEY_BITS-1:0] start_s1;
	logic [2:0][KEY_BITS-1:0] end_s1;

	// Walk state.
	logic [2:0][KEY_BITS-1:0]       cur_q;
	logic [KEY_BITS-1:0]            major_end_q;
	logic [2:0]                     dir_neg_q;
	axis_t                          major_q;
	logic [2:0][KEY_BITS:0]         twice_q;
	logic signed [1:0][ERR_W-1:0]   err_q;
	logic                           active_q;

	// Result register.
	logic                     out_v_q;
	logic [2:0][KEY_BITS-1:0] voxel_q;
	logic                     has_q;
	logic                     last_q;

	// Setup results.
	logic [2:0]                   su_dir_neg;
	axis_t                        su_major;
	logic [KEY_BITS-1:0]          su_major_end;
	logic [2:0][KEY_BITS:0]       su_twice;
	logic signed [1:0][ERR_W-1:0] su_err;
	logic                         su_active;

	// Step results.
	axis_t                        a1;
	axis_t                        a2;
	logic [KEY_BITS-1:0]          next_major;
	logic                         last;
	logic [2:0][KEY_BITS-1:0]     cur_next;
	logic signed [1:0][ERR_W-1:0] err_next;
	logic                         adv;

	lvw3d_setup #(
		.KEY_BITS(KEY_BITS)
	) u_setup (
		.start_key  (start_s1),
		.end_key    (end_s1),
		.dir_neg    (su_dir_neg),
		.major      (su_major),
		.major_end  (su_major_end),
		.twice_delta(su_twice),
		.err_init   (su_err),
		.active     (su_active)
	);

	assign adv       = v_s1 && ((mode_s1 == MODE_LOAD) || !out_v_q || rsp.ready);
	assign req.ready = !v_s1 || adv;

	always_comb begin
		unique case (major_q)
			AXIS_X: begin
				a1 = AXIS_Y;
				a2 = AXIS_Z;
			end
			AXIS_Y: begin
				a1 = AXIS_Z;
				a2 = AXIS_X;
			end
			AXIS_Z: begin
				a1 = AXIS_X;
				a2 = AXIS_Y;
			end
			default: begin
				a1 = AXIS_Y;
				a2 = AXIS_Z;
			end
		endcase

		next_major      = step_key(cur_q[major_q], dir_neg_q[major_q]);
		last            = (next_major == major_end_q);
		cur_next        = cur_q;
		cur_next[major_q] = next_major;
		err_next[0]     = err_q[0] + signed'({2'b00, twice_q[a1]});
		err_next[1]     = err_q[1] + signed'({2'b00, twice_q[a2]});
		if (!err_q[0][ERR_W-1]) begin
			cur_next[a1] = step_key(cur_q[a1], dir_neg_q[a1]);
			err_next[0]  = err_next[0] - signed'({2'b00, twice_q[major_q]});
		end
		if (!err_q[1][ERR_W-1]) begin
			cur_next[a2] = step_key(cur_q[a2], dir_neg_q[a2]);
			err_next[1]  = err_next[1] - signed'({2'b00, twice_q[major_q]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1  <= req.mode;
			start_s1 <= {req.start_z, req.start_y, req.start_x};
			end_s1   <= {req.end_z, req.end_y, req.end_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			major_end_q <= '0;
			dir_neg_q   <= '0;
			major_q     <= AXIS_X;
			twice_q     <= '0;
			err_q       <= '0;
			active_q    <= 1'b0;
		end else if (adv) begin
			if (mode_s1 == MODE_LOAD) begin
				cur_q       <= start_s1;
				major_end_q <= su_major_end;
				dir_neg_q   <= su_dir_neg;
				major_q     <= su_major;
				twice_q     <= su_twice;
				err_q       <= su_err;
				active_q    <= su_active;
			end else if (active_q) begin
				cur_q    <= cur_next;
				err_q    <= err_next;
				active_q <= !last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && (mode_s1 == MODE_NEXT)) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (mode_s1 == MODE_NEXT)) begin
			voxel_q <= active_q ? cur_q : '0;
			has_q   <= active_q;
			last_q  <= active_q && last;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.voxel_x   = voxel_q[0];
	assign rsp.voxel_y   = voxel_q[1];
	assign rsp.voxel_z   = voxel_q[2];
	assign rsp.has_voxel = has_q;
	assign rsp.is_last   = last_q;

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.has_voxel |-> (rsp.voxel_x == '0) && (rsp.voxel_y == '0)
			&& (rsp.voxel_z == '0) && !rsp.is_last)
		else $error("empty result carries a voxel");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (mode_s1 == MODE_NEXT) && active_q && last |=> !active_q)
		else $error("line still active after its last voxel");

	a_load_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (mode_s1 == MODE_LOAD) |=> active_q == $past(su_active))
		else $error("load did not set line activity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (mode_s1 == MODE_NEXT) && out_v_q && !rsp.ready |-> !adv)
		else $error("pending result overwritten");

	a_result_follows_next: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (mode_s1 == MODE_NEXT) |=> out_v_q && (has_q == $past(active_q)))
		else $error("next item gave no matching result");
endmodule

FILE: src/lvw3d_setup.sv
// Line setup: step signs, major axis, doubled deltas and initial error terms.
module lvw3d_setup #(
	parameter int KEY_BITS = lvw3d_pkg::KEY_BITS_DEF
) (
	input  logic [2:0][KEY_BITS-1:0]         start_key,
	input  logic [2:0][KEY_BITS-1:0]         end_key,
	output logic [2:0]                       dir_neg,
	output lvw3d_pkg::axis_t                 major,
	output logic [KEY_BITS-1:0]              major_end,
	output logic [2:0][KEY_BITS:0]           twice_delta,
	output logic signed [1:0][KEY_BITS+2:0]  err_init,
	output logic                             active
);
	import lvw3d_pkg::*;

	logic [2:0][KEY_BITS-1:0] mag;
	logic [2:0]               equal;
	axis_t                    a1;
	axis_t                    a2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			equal[i]       = (start_key[i] == end_key[i]);
			dir_neg[i]     = equal[i] || (end_key[i] < start_key[i]);
			mag[i]         = dir_neg[i] ? (start_key[i] - end_key[i])
			                            : (end_key[i] - start_key[i]);
			twice_delta[i] = {mag[i], 1'b0};
		end

		major = AXIS_X;
		if (mag[1] > mag[0]) begin
			major = AXIS_Y;
		end
		if (mag[2] > mag[major]) begin
			major = AXIS_Z;
		end

		unique case (major)
			AXIS_X: begin
				a1 = AXIS_Y;
				a2 = AXIS_Z;
			end
			AXIS_Y: begin
				a1 = AXIS_Z;
				a2 = AXIS_X;
			end
			AXIS_Z: begin
				a1 = AXIS_X;
				a2 = AXIS_Y;
			end
			default: begin
				a1 = AXIS_Y;
				a2 = AXIS_Z;
			end
		endcase

		major_end   = end_key[major];
		err_init[0] = signed'({2'b00, twice_delta[a1]}) - signed'({3'b000, mag[major]});
		err_init[1] = signed'({2'b00, twice_delta[a2]}) - signed'({3'b000, mag[major]});
		active      = (mag[major] != '0);
	end
endmodule
